// ===== rtl/core/mpc_pkg.sv =====
// Shared types, constants and helper functions of the Mandelbrot pixel colorizer.
`default_nettype none

package mpc_pkg;

	localparam int unsigned COLUMNS   = 64;
	localparam int unsigned ROWS      = 32;
	localparam int unsigned COL_W     = $clog2(COLUMNS);
	localparam int unsigned ROW_W     = $clog2(ROWS);
	localparam int unsigned FRAC_BITS = 60;
	localparam int unsigned MAX_ITER  = 100;
	localparam int unsigned CNT_W     = 7;
	localparam int unsigned NUM_BANDS = 13;
	localparam int unsigned NUM_THR   = 11;

	// Escape bound 4.0 expressed in the Q8.120 format of a full square.
	localparam logic [127:0] FOUR_Q120 = 128'd1 << (2 * FRAC_BITS + 2);

	// Multiplier sequencing: phase of the last of four partial products, and of the finishing step.
	localparam logic [2:0] MUL_LAST_PART = 3'd3;
	localparam logic [2:0] MUL_FINISH    = 3'd5;

	typedef enum logic [2:0] {
		REG_X_ORIGIN = 3'd0,
		REG_X_STEP   = 3'd1,
		REG_Y_TOP    = 3'd2,
		REG_Y_STEP   = 3'd3,
		REG_DEEP     = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CR,
		S_CR_W,
		S_CI,
		S_CI_W,
		S_SQR,
		S_SQR_W,
		S_SQI,
		S_SQI_W,
		S_MAG,
		S_CROSS,
		S_CROSS_W,
		S_UPD,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [63:0] x_origin;
		logic [63:0] x_step;
		logic [63:0] y_top;
		logic [63:0] y_step;
		logic        deep_palette;
	} cfg_t;

	typedef struct packed {
		logic go;
		logic sgn;
	} mul_req_t;

	typedef struct packed {
		logic             done;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [CNT_W-1:0] count;
	} seq_rsp_t;

	localparam logic [23:0] BAND_RGB [NUM_BANDS] = '{
		24'h000000, 24'hFF0000, 24'hFF7F7F, 24'hFFA500, 24'hFFFF00,
		24'h7FFF7F, 24'h00FF00, 24'h7FFFFF, 24'h00FFFF,
		24'h7F7FFF, 24'h0000FF, 24'hFF00FF, 24'hFF7FFF
	};

	localparam logic [CNT_W-1:0] THR_NORMAL [NUM_THR] = '{
		7'd90, 7'd70, 7'd50, 7'd30, 7'd20, 7'd10, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1
	};

	localparam logic [CNT_W-1:0] THR_DEEP [NUM_THR] = '{
		7'd99, 7'd98, 7'd96, 7'd94, 7'd92, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd60
	};

	// Band index for a count: the first descending threshold that the count reaches.
	function automatic logic [3:0] band_of(input logic [CNT_W-1:0] count, input logic deep);
		logic [3:0] band;
		logic [CNT_W-1:0] thr;
		band = 4'(NUM_BANDS - 1);
		for (int k = NUM_THR - 1; k >= 0; k--) begin
			thr = deep ? THR_DEEP[k] : THR_NORMAL[k];
			if (count >= thr) begin
				band = 4'(k + 1);
			end
		end
		if (count >= CNT_W'(MAX_ITER)) begin
			band = 4'd0;
		end
		return band;
	endfunction

	// Clamp a signed 128-bit value into the signed 64-bit range.
	function automatic logic [63:0] sat64(input logic [127:0] x);
		logic [63:0] r;
		if (x[127:63] == {65{x[63]}}) begin
			r = x[63:0];
		end else if (x[127]) begin
			r = {1'b1, 63'd0};
		end else begin
			r = {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mpc_apb.sv =====
// Configuration register file behind an APB-style port.
`default_nettype none

module mpc_apb (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [5:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	output mpc_pkg::cfg_t     cfg
);
	import mpc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[5:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_X_ORIGIN: cfg_q.x_origin     <= pwdata;
				REG_X_STEP:   cfg_q.x_step       <= pwdata;
				REG_Y_TOP:    cfg_q.y_top        <= pwdata;
				REG_Y_STEP:   cfg_q.y_step       <= pwdata;
				REG_DEEP:     cfg_q.deep_palette <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_X_ORIGIN: prdata = cfg_q.x_origin;
			REG_X_STEP:   prdata = cfg_q.x_step;
			REG_Y_TOP:    prdata = cfg_q.y_top;
			REG_Y_STEP:   prdata = cfg_q.y_step;
			REG_DEEP:     prdata = {63'd0, cfg_q.deep_palette};
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/mpc_mul.sv =====
// Shared 64x64 multiplier built sequentially from four 32x32 partial products.
`default_nettype none

module mpc_mul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mpc_pkg::mul_req_t req,
	input  wire logic [63:0]   a,
	input  wire logic [63:0]   b,
	output logic               done,
	output logic [127:0]       prod
);
	import mpc_pkg::*;

	logic         run_q;
	logic [2:0]   ph_q;
	logic         done_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [127:0] p_q;
	logic [63:0]  part_s1;
	logic [1:0]   sh_s1;
	logic [31:0]  ah;
	logic [31:0]  bh;
	logic [1:0]   sh;
	logic [127:0] addend;

	// Operand halves and weight of the partial product for this phase.
	always_comb begin
		case (ph_q[1:0])
			2'd0:    begin ah = a_q[31:0];  bh = b_q[31:0];  sh = 2'd0; end
			2'd1:    begin ah = a_q[31:0];  bh = b_q[63:32]; sh = 2'd1; end
			2'd2:    begin ah = a_q[63:32]; bh = b_q[31:0];  sh = 2'd1; end
			default: begin ah = a_q[63:32]; bh = b_q[63:32]; sh = 2'd2; end
		endcase
	end

	always_comb begin
		case (sh_s1)
			2'd0:    addend = {64'd0, part_s1};
			2'd1:    addend = {32'd0, part_s1, 32'd0};
			default: addend = {part_s1, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ph_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (ph_q == MUL_FINISH);
			if (req.go) begin
				run_q <= 1'b1;
				ph_q  <= '0;
			end else if (run_q) begin
				if (ph_q == MUL_FINISH) begin
					run_q <= 1'b0;
				end
				ph_q <= ph_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q   <= (req.sgn && a[63]) ? (64'd0 - a) : a;
			b_q   <= (req.sgn && b[63]) ? (64'd0 - b) : b;
			neg_q <= req.sgn && (a[63] ^ b[63]);
			acc_q <= '0;
		end else if (run_q) begin
			if (ph_q <= MUL_LAST_PART) begin
				part_s1 <= ah * bh;
				sh_s1   <= sh;
			end
			if (ph_q >= 3'd1 && ph_q <= MUL_LAST_PART + 3'd1) begin
				acc_q <= acc_q + addend;
			end
			if (ph_q == MUL_FINISH) begin
				p_q <= neg_q ? (128'd0 - acc_q) : acc_q;
			end
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

`default_nettype wire

// ===== rtl/core/mpc_seq.sv =====
// Sequencer and datapath of the escape-time iteration around the shared multiplier.
`default_nettype none

module mpc_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [mpc_pkg::COL_W-1:0] pixel_col,
	input  wire logic [mpc_pkg::ROW_W-1:0] pixel_row,
	input  wire mpc_pkg::cfg_t             cfg,
	output logic                           busy,
	output mpc_pkg::seq_rsp_t              rsp
);
	import mpc_pkg::*;

	seq_state_t       state_q;
	seq_state_t       state_d;
	mul_req_t         mreq;
	logic [63:0]      op_a;
	logic [63:0]      op_b;
	logic             mdone;
	logic [127:0]     mprod;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] iter_q;
	logic [CNT_W-1:0] count_q;
	logic [63:0]      cr_q;
	logic [63:0]      ci_q;
	logic [63:0]      zr_q;
	logic [63:0]      zi_q;
	logic [127:0]     r2_q;
	logic [127:0]     diff_q;
	logic [127:0]     mag;
	logic             escaped;
	logic [63:0]      ci_new;
	logic [127:0]     zi_wide;
	logic [127:0]     zr_wide;

	mpc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.a      (op_a),
		.b      (op_b),
		.done   (mdone),
		.prod   (mprod)
	);

	assign mag     = r2_q + mprod;
	assign escaped = mag > FOUR_Q120;
	assign ci_new  = cfg.y_top - mprod[63:0];
	assign zi_wide = 128'($signed(mprod) >>> (FRAC_BITS - 1)) + {{64{ci_q[63]}}, ci_q};
	assign zr_wide = 128'($signed(diff_q) >>> FRAC_BITS) + {{64{cr_q[63]}}, cr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mreq.go  = 1'b0;
		mreq.sgn = 1'b1;
		op_a     = zr_q;
		op_b     = zr_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CR;
			end
			S_CR: begin
				mreq.go  = 1'b1;
				mreq.sgn = 1'b0;
				op_a     = cfg.x_step;
				op_b     = 64'(col_q);
				state_d  = S_CR_W;
			end
			S_CR_W: begin
				if (mdone) state_d = S_CI;
			end
			S_CI: begin
				mreq.go  = 1'b1;
				mreq.sgn = 1'b0;
				op_a     = cfg.y_step;
				op_b     = 64'(row_q);
				state_d  = S_CI_W;
			end
			S_CI_W: begin
				if (mdone) state_d = S_SQR;
			end
			S_SQR: begin
				mreq.go = 1'b1;
				state_d = S_SQR_W;
			end
			S_SQR_W: begin
				if (mdone) state_d = S_SQI;
			end
			S_SQI: begin
				mreq.go = 1'b1;
				op_a    = zi_q;
				op_b    = zi_q;
				state_d = S_SQI_W;
			end
			S_SQI_W: begin
				if (mdone) state_d = S_MAG;
			end
			S_MAG: begin
				state_d = escaped ? S_DONE : S_CROSS;
			end
			S_CROSS: begin
				mreq.go = 1'b1;
				op_b    = zi_q;
				state_d = S_CROSS_W;
			end
			S_CROSS_W: begin
				if (mdone) state_d = S_UPD;
			end
			S_UPD: begin
				state_d = (iter_q == CNT_W'(MAX_ITER - 1)) ? S_DONE : S_SQR;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					col_q <= pixel_col;
					row_q <= pixel_row;
				end
			end
			S_CR_W: begin
				if (mdone) cr_q <= cfg.x_origin + mprod[63:0];
			end
			S_CI_W: begin
				if (mdone) begin
					ci_q   <= ci_new;
					zr_q   <= cr_q;
					zi_q   <= ci_new;
					iter_q <= '0;
				end
			end
			S_SQR_W: begin
				if (mdone) r2_q <= mprod;
			end
			S_MAG: begin
				diff_q  <= r2_q - mprod;
				count_q <= iter_q;
			end
			S_UPD: begin
				zr_q    <= sat64(zr_wide);
				zi_q    <= sat64(zi_wide);
				iter_q  <= iter_q + CNT_W'(1);
				count_q <= CNT_W'(MAX_ITER);
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign rsp.done  = (state_q == S_DONE);
	assign rsp.col   = col_q;
	assign rsp.row   = row_q;
	assign rsp.count = count_q;

endmodule

`default_nettype wire

// ===== rtl/core/mandelbrot_pixel_colorizer.sv =====
// Top level of the Mandelbrot pixel colorizer: configuration, iteration engine, palette output.
`default_nettype none

// The block takes one pixel word (pixel_col, pixel_row) when start is high and busy is low,
// forms the point c = (x_origin + col*x_step, y_top - row*y_step) in signed Q4.60 and runs
// the escape-time iteration z = z*z + c from z = c for at most 100 steps, leaving as soon as
// the exact Q8.120 value of |z|^2 exceeds 4.0. The result word (echoed column and row, the
// escape count with 100 meaning the point stayed bounded, and an RGB band color) appears on
// the output ports for exactly one cycle, marked by done; the receiver cannot stall it, so it
// must take every word in that cycle. All 64-bit products go through one shared multiplier
// built from four 32x32 partial products. Forming the point costs two products, and each
// iteration costs three products (the two squares and the cross product) plus the MAG
// and UPD steps; an escaping iteration stops after the two squares and the MAG step.
// The block works on one pixel at a time and holds busy high until the iteration ends; the
// next pixel can be started in the cycle in which done is shown. Configuration registers sit
// at byte addresses 0, 8, 16, 24 and 32 of the 64-bit APB port and may only be written while
// busy is low.

module mandelbrot_pixel_colorizer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [5:0]                paddr,
	input  wire logic [63:0]               pwdata,
	output logic [63:0]                    prdata,
	output logic                           pready,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [mpc_pkg::COL_W-1:0] pixel_col,
	input  wire logic [mpc_pkg::ROW_W-1:0] pixel_row,
	output logic                           done,
	output logic [mpc_pkg::COL_W-1:0]      out_col,
	output logic [mpc_pkg::ROW_W-1:0]      out_row,
	output logic [mpc_pkg::CNT_W-1:0]      escape_count,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue
);
	import mpc_pkg::*;

	cfg_t             cfg;
	seq_rsp_t         rsp;
	logic             seq_busy;
	logic [3:0]       band;
	logic [23:0]      rgb;

	logic             done_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] count_q;
	logic [23:0]      rgb_q;

	mpc_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mpc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.cfg       (cfg),
		.busy      (seq_busy),
		.rsp       (rsp)
	);

	// The palette lookup sits between the final count and the output register.
	assign band = band_of(rsp.count, cfg.deep_palette);
	assign rgb  = BAND_RGB[band];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rsp.done;
		end
	end

	// Result payload is loaded once per pixel, when the sequencer reports done, and held until the next result.
	always_ff @(posedge clk) begin
		if (rsp.done) begin
			col_q   <= rsp.col;
			row_q   <= rsp.row;
			count_q <= rsp.count;
			rgb_q   <= rgb;
		end
	end

	assign busy         = seq_busy;
	assign done         = done_q;
	assign out_col      = col_q;
	assign out_row      = row_q;
	assign escape_count = count_q;
	assign red          = rgb_q[23:16];
	assign green        = rgb_q[15:8];
	assign blue         = rgb_q[7:0];

endmodule

`default_nettype wire

// ===== rtl/core/mpc_checker.sv =====
// Port-level checker for the Mandelbrot pixel colorizer and its bind to the top level.
`default_nettype none

module mpc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [6:0] escape_count,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue
);

	// An accepted pixel word always makes the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted pixel did not raise busy");

	// A result word follows a busy cycle and never repeats in the next cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !$past(done)))
		else $error("result word without a preceding busy cycle");

	// The escape count never passes the iteration limit.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (escape_count <= 7'd100))
		else $error("escape count out of range");

	// Bounded points are always black.
	a_bounded_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && escape_count == 7'd100) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("bounded point not black");

endmodule

bind mandelbrot_pixel_colorizer mpc_checker u_mpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.escape_count (escape_count),
	.red          (red),
	.green        (green),
	.blue         (blue)
);

`default_nettype wire
